// ===== src/mcbs_pkg.sv =====
// shared widths, codes and pipeline lane type for the mip chain byte size block
package mcbs_pkg;

  localparam int MAX_LEVELS = 16;

  localparam int DIM_W   = 15;
  localparam int DEPTH_W = 12;
  localparam int KIND_W  = 2;
  localparam int PIX_W   = 5;
  localparam int LEVEL_W = 4;
  localparam int COUNT_W = 5;
  localparam int SIZE_W  = 40;

  localparam int WH_W    = 2 * DIM_W;
  localparam int SUM_W   = 44;
  localparam int SCALE_W = SUM_W + PIX_W;
  localparam int TOTAL_W = SCALE_W + 3;

  localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(MAX_LEVELS);
  localparam logic [SIZE_W-1:0]  SIZE_MAX  = {SIZE_W{1'b1}};

  typedef enum logic [KIND_W-1:0] {
    KIND_PLAIN = 2'd0,
    KIND_BC8   = 2'd1,
    KIND_BC16  = 2'd2,
    KIND_SPARE = 2'd3
  } kind_t;

  localparam logic [PIX_W-1:0] UNIT_BC8  = PIX_W'(8);
  localparam logic [PIX_W-1:0] UNIT_BC16 = PIX_W'(16);

  // one item as it moves down the level pipeline
  typedef struct packed {
    logic               valid;
    logic [DIM_W-1:0]   w;
    logic [DIM_W-1:0]   h;
    logic [DEPTH_W-1:0] d;
    logic               pend;
    logic [WH_W-1:0]    wh;
    logic [DEPTH_W-1:0] dp;
    logic [SUM_W-1:0]   sum;
    logic [COUNT_W-1:0] remaining;
    logic               compressed;
    logic [PIX_W-1:0]   unit;
    logic               cube;
  } lane_t;

endpackage

// ===== src/mcbs_if.sv =====
// request and response channel interfaces
interface mcbs_req_if;
  import mcbs_pkg::*;
  logic               valid;
  logic               ready;
  logic [DIM_W-1:0]   base_width;
  logic [DIM_W-1:0]   base_height;
  logic [DEPTH_W-1:0] base_depth;
  logic [KIND_W-1:0]  format_kind;
  logic [PIX_W-1:0]   pixel_bytes;
  logic [LEVEL_W-1:0] first_level;
  logic [COUNT_W-1:0] level_count;

  modport source(output valid, base_width, base_height, base_depth, format_kind,
                 pixel_bytes, first_level, level_count, input ready);
  modport sink(input valid, base_width, base_height, base_depth, format_kind,
               pixel_bytes, first_level, level_count, output ready);
endinterface

interface mcbs_rsp_if;
  import mcbs_pkg::*;
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] byte_size;

  modport source(output valid, byte_size, input ready);
  modport sink(input valid, byte_size, output ready);
endinterface

// ===== src/mcbs_level_stage.sv =====
// one mip level of the pipeline: adds the previous level's texel count, starts the next
module mcbs_level_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  mcbs_pkg::lane_t prev,
  output mcbs_pkg::lane_t cur
);
  import mcbs_pkg::*;

  lane_t              nxt;
  logic [DIM_W:0]     w_round;
  logic [DIM_W:0]     h_round;
  logic [DIM_W-1:0]   ew;
  logic [DIM_W-1:0]   eh;
  logic               last_level;
  logic [SUM_W-1:0]   whd;

  always_comb begin
    w_round = {1'b0, prev.w} + (DIM_W+1)'(3);
    h_round = {1'b0, prev.h} + (DIM_W+1)'(3);
    // compressed formats count 4x4 blocks
    ew = prev.compressed ? DIM_W'(w_round >> 2) : prev.w;
    eh = prev.compressed ? DIM_W'(h_round >> 2) : prev.h;
    last_level = (prev.w == DIM_W'(1)) && (prev.h == DIM_W'(1)) && (prev.d == DEPTH_W'(1));
    whd = prev.pend ? SUM_W'(prev.wh * prev.dp) : '0;

    nxt     = prev;
    nxt.sum = prev.sum + whd;
    if (prev.remaining != '0) begin
      nxt.pend      = 1'b1;
      nxt.wh        = WH_W'(ew * eh);
      nxt.dp        = prev.d;
      nxt.remaining = last_level ? '0 : prev.remaining - COUNT_W'(1);
      nxt.w         = (prev.w > DIM_W'(1)) ? prev.w >> 1 : prev.w;
      nxt.h         = (prev.h > DIM_W'(1)) ? prev.h >> 1 : prev.h;
      nxt.d         = (prev.d > DEPTH_W'(1)) ? prev.d >> 1 : prev.d;
    end else begin
      nxt.pend = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else if (en) begin
      cur <= nxt;
    end
  end

endmodule

// ===== src/mip_chain_byte_size_top.sv =====
// top level: byte size of a run of mip levels, one pipeline stage per level
//
//   channel  dir  fields
//   req      in   base_width, base_height, base_depth, format_kind,
//                 pixel_bytes, first_level, level_count
//   rsp      out  byte_size
//
// an item enters every cycle unless the pipeline holds; stages in order:
// entry, one stage per level, a final add, the bytes-per-unit multiply, cube scaling
// the whole pipeline advances together and holds when the result register is
// full and not taken; req.ready is that advance enable
// synchronous reset clears the valid bits only
module mip_chain_byte_size_top (
  input  logic       clk,
  input  logic       rst,
  mcbs_req_if.sink   req,
  mcbs_rsp_if.source rsp
);
  import mcbs_pkg::*;

  logic               adv;
  lane_t              lane [MAX_LEVELS+1];
  lane_t              entry_next;
  logic [DIM_W-1:0]   w0;
  logic [DIM_W-1:0]   h0;
  logic [DEPTH_W-1:0] d0;

  logic               fin_valid;
  logic [SUM_W-1:0]   fin_sum;
  logic [PIX_W-1:0]   fin_unit;
  logic               fin_cube;

  logic               scl_valid;
  logic [SCALE_W-1:0] scl_val;
  logic               scl_cube;

  logic [TOTAL_W-1:0] total;
  logic               out_valid;
  logic [SIZE_W-1:0]  out_size;

  assign adv       = !out_valid || rsp.ready;
  assign req.ready = adv;

  // entry: clamp the first level's dimensions, cap the count, pick the unit
  always_comb begin
    w0 = req.base_width >> req.first_level;
    h0 = req.base_height >> req.first_level;
    d0 = req.base_depth >> req.first_level;

    entry_next            = '0;
    entry_next.valid      = req.valid;
    entry_next.w          = (w0 == '0) ? DIM_W'(1) : w0;
    entry_next.h          = (h0 == '0) ? DIM_W'(1) : h0;
    entry_next.cube       = (req.base_depth == '0);
    entry_next.d          = (entry_next.cube || d0 == '0) ? DEPTH_W'(1) : d0;
    entry_next.remaining  = (req.level_count > COUNT_CAP) ? COUNT_CAP : req.level_count;
    entry_next.compressed = (kind_t'(req.format_kind) != KIND_PLAIN);
    unique case (kind_t'(req.format_kind))
      KIND_PLAIN: entry_next.unit = req.pixel_bytes;
      KIND_BC8:   entry_next.unit = UNIT_BC8;
      default:    entry_next.unit = UNIT_BC16;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane[0].valid <= 1'b0;
    end else if (adv) begin
      lane[0] <= entry_next;
    end
  end

  for (genvar i = 0; i < MAX_LEVELS; i++) begin : g_level
    mcbs_level_stage u_stage (
      .clk  (clk),
      .rst  (rst),
      .en   (adv),
      .prev (lane[i]),
      .cur  (lane[i+1])
    );
  end

  // tail: last pending level, then bytes per unit, then cube faces and clamp
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
      scl_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      fin_valid <= lane[MAX_LEVELS].valid;
      scl_valid <= fin_valid;
      out_valid <= scl_valid;
    end
  end

  always_comb begin
    total = scl_cube ? (TOTAL_W'(scl_val) << 2) + (TOTAL_W'(scl_val) << 1)
                     : TOTAL_W'(scl_val);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fin_sum  <= lane[MAX_LEVELS].sum +
                  (lane[MAX_LEVELS].pend ?
                   SUM_W'(lane[MAX_LEVELS].wh * lane[MAX_LEVELS].dp) : SUM_W'(0));
      fin_unit <= lane[MAX_LEVELS].unit;
      fin_cube <= lane[MAX_LEVELS].cube;
      scl_val  <= SCALE_W'(fin_sum * fin_unit);
      scl_cube <= fin_cube;
      out_size <= (|total[TOTAL_W-1:SIZE_W]) ? SIZE_MAX : total[SIZE_W-1:0];
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.byte_size = out_size;

endmodule

// ===== dv/tb.sv =====
// testbench for the mip chain byte size block: random and directed items, model check
`timescale 1ns / 1ps

module tb;
  import mcbs_pkg::*;

  localparam int CYCLE_LIMIT = 100000;
  localparam int DRAIN_CYCLES = 2 * (MAX_LEVELS + 4);
  localparam int PHASE_ITEMS = 250;

  typedef struct packed {
    logic [DIM_W-1:0]   base_width;
    logic [DIM_W-1:0]   base_height;
    logic [DEPTH_W-1:0] base_depth;
    kind_t              format_kind;
    logic [PIX_W-1:0]   pixel_bytes;
    logic [LEVEL_W-1:0] first_level;
    logic [COUNT_W-1:0] level_count;
  } tex_desc_t;

  logic clk;
  logic rst;

  mcbs_req_if req_ch();
  mcbs_rsp_if rsp_ch();

  mip_chain_byte_size_top u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  tex_desc_t         desc_queue[$];
  logic [SIZE_W-1:0] size_queue[$];

  int  send_idle_pct = 0;
  int  rsp_stall_pct = 0;
  int  hold_goal = 0;
  int  hold_done = 0;
  int  fail_cnt = 0;
  int  cycle_cnt = 0;
  bit  desc_taken = 1'b0;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // byte size of the requested run of mip levels
  function automatic logic [SIZE_W-1:0] mip_run_bytes(tex_desc_t t);
    longint unsigned w, h, d, sum, unit, total;
    int  n, i;
    bit  cube, packed_fmt;
    n = (t.level_count > MAX_LEVELS) ? MAX_LEVELS : int'(t.level_count);
    cube = (t.base_depth == '0);
    packed_fmt = (t.format_kind != KIND_PLAIN);
    w = t.base_width;
    h = t.base_height;
    d = t.base_depth;
    w = w >> t.first_level;
    h = h >> t.first_level;
    d = d >> t.first_level;
    if (w == 0) w = 1;
    if (h == 0) h = 1;
    if (d == 0 || cube) d = 1;
    sum = 0;
    for (i = 0; i < n; i++) begin
      if (packed_fmt) sum += ((w + 3) >> 2) * ((h + 3) >> 2) * d;
      else sum += w * h * d;
      if (w == 1 && h == 1 && d == 1) break;
      if (w > 1) w = w >> 1;
      if (h > 1) h = h >> 1;
      if (d > 1) d = d >> 1;
    end
    if (!packed_fmt) unit = t.pixel_bytes;
    else if (t.format_kind == KIND_BC8) unit = 8;
    else unit = 16;
    total = sum * unit;
    if (cube) total = total * 6;
    if (total > SIZE_MAX) total = SIZE_MAX;
    return total[SIZE_W-1:0];
  endfunction

  function automatic logic [DIM_W-1:0] rand_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return DIM_W'(1 << $urandom_range(0, 14));
    if (r < 80) return DIM_W'($urandom_range(0, 300));
    return DIM_W'($urandom_range(0, (1 << DIM_W) - 1));
  endfunction

  function automatic tex_desc_t rand_desc();
    tex_desc_t t;
    int r;
    t.base_width = rand_dim();
    t.base_height = rand_dim();
    r = $urandom_range(0, 99);
    if (r < 25) t.base_depth = '0;
    else if (r < 65) t.base_depth = DEPTH_W'(1);
    else if (r < 85) t.base_depth = DEPTH_W'(1 << $urandom_range(0, 11));
    else t.base_depth = DEPTH_W'($urandom_range(0, (1 << DEPTH_W) - 1));
    t.format_kind = kind_t'($urandom_range(0, 3));
    if ($urandom_range(0, 99) < 85) t.pixel_bytes = PIX_W'($urandom_range(1, 16));
    else t.pixel_bytes = PIX_W'($urandom_range(0, 31));
    if ($urandom_range(0, 1) == 0) t.first_level = '0;
    else t.first_level = LEVEL_W'($urandom_range(0, 15));
    if ($urandom_range(0, 99) < 80) t.level_count = COUNT_W'($urandom_range(0, 16));
    else t.level_count = COUNT_W'($urandom_range(0, 31));
    return t;
  endfunction

  task automatic add_desc(int w, int h, int d, kind_t k, int p, int f, int n);
    tex_desc_t t;
    t.base_width = DIM_W'(w);
    t.base_height = DIM_W'(h);
    t.base_depth = DEPTH_W'(d);
    t.format_kind = k;
    t.pixel_bytes = PIX_W'(p);
    t.first_level = LEVEL_W'(f);
    t.level_count = COUNT_W'(n);
    desc_queue.push_back(t);
  endtask

  task automatic add_random(int cnt);
    repeat (cnt) desc_queue.push_back(rand_desc());
  endtask

  task automatic wait_drained();
    while (desc_queue.size() != 0 || req_ch.valid || size_queue.size() != 0)
      @(negedge clk);
  endtask

  // request driver
  always @(negedge clk) begin
    tex_desc_t t;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || desc_taken) begin
      if (desc_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        t = desc_queue.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.base_width <= t.base_width;
        req_ch.base_height <= t.base_height;
        req_ch.base_depth <= t.base_depth;
        req_ch.format_kind <= t.format_kind;
        req_ch.pixel_bytes <= t.pixel_bytes;
        req_ch.first_level <= t.first_level;
        req_ch.level_count <= t.level_count;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // response ready, with one long hold-off counted here
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_done < hold_goal) begin
      rsp_ch.ready <= 1'b0;
      hold_done <= hold_done + 1;
    end else begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
    end
  end

  // accepted items become expected sizes; results are checked in order
  always @(posedge clk) begin
    tex_desc_t t;
    logic [SIZE_W-1:0] want;
    if (!rst && req_ch.valid && req_ch.ready) begin
      t.base_width = req_ch.base_width;
      t.base_height = req_ch.base_height;
      t.base_depth = req_ch.base_depth;
      t.format_kind = kind_t'(req_ch.format_kind);
      t.pixel_bytes = req_ch.pixel_bytes;
      t.first_level = req_ch.first_level;
      t.level_count = req_ch.level_count;
      size_queue.push_back(mip_run_bytes(t));
      desc_taken <= 1'b1;
    end else begin
      desc_taken <= 1'b0;
    end
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (size_queue.size() == 0) begin
        $error("unexpected item: byte_size %0d", rsp_ch.byte_size);
        fail_cnt++;
      end else begin
        want = size_queue.pop_front();
        if (rsp_ch.byte_size !== want) begin
          $error("byte_size mismatch: expected %0d, actual %0d", want, rsp_ch.byte_size);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.base_width = '0;
    req_ch.base_height = '0;
    req_ch.base_depth = '0;
    req_ch.format_kind = '0;
    req_ch.pixel_bytes = '0;
    req_ch.first_level = '0;
    req_ch.level_count = '0;
    rsp_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: field extremes, every format kind, special cases
    add_desc(16384, 16384, 2048, KIND_PLAIN, 16, 0, 16);
    add_desc(32767, 32767, 4095, KIND_PLAIN, 31, 0, 31);   // saturates
    add_desc(32767, 32767, 0, KIND_BC16, 0, 0, 16);        // large cube
    add_desc(16384, 16384, 0, KIND_PLAIN, 16, 0, 16);
    add_desc(0, 0, 1, KIND_PLAIN, 4, 0, 1);                // zero dims act as one
    add_desc(0, 0, 0, KIND_BC8, 1, 0, 16);
    add_desc(1, 1, 1, KIND_PLAIN, 4, 0, 16);               // stops after one level
    add_desc(256, 256, 1, KIND_PLAIN, 4, 0, 0);            // empty run
    add_desc(256, 256, 1, KIND_PLAIN, 0, 0, 9);            // zero bytes per texel
    add_desc(256, 128, 1, KIND_PLAIN, 31, 2, 5);
    add_desc(256, 256, 16, KIND_BC8, 4, 0, 16);
    add_desc(256, 256, 16, KIND_BC16, 4, 0, 16);
    add_desc(256, 256, 16, KIND_SPARE, 4, 0, 16);          // unused kind
    add_desc(5, 3, 1, KIND_BC8, 1, 0, 4);
    add_desc(13, 7, 3, KIND_BC16, 1, 1, 3);
    add_desc(1024, 512, 64, KIND_PLAIN, 8, 15, 16);        // last first level
    add_desc(1024, 1024, 1, KIND_PLAIN, 2, 3, 20);         // count above cap
    add_desc(4096, 16, 2048, KIND_PLAIN, 1, 0, 16);
    add_desc(64, 64, 0, KIND_PLAIN, 4, 0, 7);              // cube
    add_desc(64, 64, 0, KIND_BC16, 4, 6, 2);
    wait_drained();

    add_random(PHASE_ITEMS);
    wait_drained();

    send_idle_pct = 85;
    add_random(PHASE_ITEMS);
    wait_drained();

    send_idle_pct = 0;
    rsp_stall_pct = 85;
    add_random(PHASE_ITEMS);
    wait_drained();

    send_idle_pct = 37;
    rsp_stall_pct = 37;
    add_random(PHASE_ITEMS);
    wait_drained();

    // long receiver hold-off while the sender keeps offering items
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    hold_goal = 300;
    add_random(80);
    wait_drained();

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/mcbs_pkg.sv
src/mcbs_if.sv
src/mcbs_level_stage.sv
src/mip_chain_byte_size_top.sv
dv/tb.sv
